// ----- design/anbs_pkg.sv -----
// Shared types and constants for the Annex B NAL unit splitter.
// Used by every module of the block; depends on nothing.
package anbs_pkg;

    localparam int unsigned StoreBytesDef = 30;
    localparam int unsigned QueueDepth    = 4;

    localparam logic [4:0] TypeIdr = 5'd5;
    localparam logic [4:0] TypeSps = 5'd7;
    localparam logic [4:0] TypePps = 5'd8;

    localparam logic [2:0] SyncLast = 3'd3;
    localparam logic [2:0] SyncDone = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [4:0] unit_type;
        logic       unit_first;
        logic       unit_last;
        logic       replayed;
    } t_out;

    typedef enum logic {
        CmdByte   = 1'b0,
        CmdReplay = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [4:0] utype;
        logic       first;
        logic       last;
    } t_cmd;

endpackage

// ----- design/annexb_nal_splitter_with_config_repeat_core.sv -----
// Top level of the Annex B NAL unit splitter with parameter set replay.
// Depends on anbs_pkg, anbs_front, anbs_cmdq and anbs_back.
//
// Input bytes enter through a queue-like port: a byte is taken when i_push
// is high and o_full is low; buffer_last marks the final byte of a buffer.
// Unit bytes leave through a queue-like port: the oldest byte is on o_out
// while o_empty is low and is taken when i_pop is high.
// The repeat register is written through i_cfg_valid/o_cfg_ready; the user
// must write it only while the block is idle; the block does not enforce it.
// A unit byte is held until four more bytes rule out a start code. It enters
// the command queue at the edge that takes the byte releasing it, and passes
// from the queue into the output register that drives o_out. The front part
// takes one byte per cycle while o_full is low; a byte that ends a buffer
// and releases more than one command (up to five) holds the input until all
// of them have entered the queue. When the repeat register is set and valid
// SPS and PPS are stored, the back part replays them before an IDR unit at
// one byte per cycle while the output is not stalled; the command queue lets
// input continue meanwhile until it fills. When the receiver stalls, results
// wait in the output register and the queue, and o_full rises once both fill.
// Reset empties the queue and output, clears stored SPS/PPS validity and
// sets the repeat register to 0.
module annexb_nal_splitter_with_config_repeat_core #(
    parameter int unsigned STORE_BYTES = anbs_pkg::StoreBytesDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  anbs_pkg::t_in  i_in,
    output logic           o_empty,
    input  logic           i_pop,
    output anbs_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_data
);

    logic           r_repeat;
    logic           q_push, q_full, q_pop, q_empty;
    anbs_pkg::t_cmd q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_repeat <= i_cfg_data;
        end
    end

    anbs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    anbs_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    anbs_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_repeat  (r_repeat),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_out     (o_out)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("output not empty after reset");

    a_replay_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.replayed && o_out.unit_first) |->
        (o_out.unit_type == anbs_pkg::TypeSps || o_out.unit_type == anbs_pkg::TypePps))
        else $error("replayed unit is not a parameter set");

    a_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

endmodule

// ----- design/anbs_front.sv -----
// Front part: start code search, unit classification and command generation.
// Depends on anbs_pkg; feeds anbs_cmdq.
module anbs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  anbs_pkg::t_in i_in,
    input  logic          i_q_full,
    output logic          o_q_push,
    output anbs_pkg::t_cmd o_q_cmd
);

    logic [2:0] r_sync, n_sync;
    logic       r_drop, n_drop;
    logic       r_hp, n_hp;
    logic [2:0] r_hcnt, n_hcnt;
    logic [4:0] r_ctype, n_ctype;
    logic [7:0] r_hold [4];
    logic [7:0] n_hold [4];

    logic       r_p_rep, n_p_rep;
    logic [7:0] r_p_byte [5];
    logic [7:0] n_p_byte [5];
    logic [2:0] r_p_idx, n_p_idx;
    logic [2:0] r_p_end, n_p_end;
    logic       r_p_hdr, n_p_hdr;
    logic       r_p_last, n_p_last;
    logic [4:0] r_p_type, n_p_type;

    logic       acc;
    logic [7:0] b;
    logic [7:0] seq [5];
    logic       m4, m5, sc, hdr;
    logic       f_rep, f_last;
    logic [2:0] f_end;
    logic [4:0] f_type;
    logic       s_rep, s_hdr, s_last;
    logic [2:0] s_idx, s_end;
    logic [4:0] s_type;
    logic [7:0] s_bytes [5];
    logic       push;

    assign o_full = r_p_rep || (r_p_idx != r_p_end) || i_q_full;
    assign acc    = i_push && !o_full;
    assign b      = i_in.data_byte;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < r_hcnt) begin
                seq[i] = r_hold[i];
            end else if (3'(i) == r_hcnt) begin
                seq[i] = b;
            end else begin
                seq[i] = 8'h00;
            end
        end
        seq[4] = (r_hcnt == 3'd4) ? b : 8'h00;
        m4 = (r_hcnt == 3'd3);
        m5 = (r_hcnt == 3'd4);
        sc = (m4 && seq[0] == 8'h00 && seq[1] == 8'h00 && seq[2] == 8'h00
              && seq[3] == 8'h01)
          || (m5 && seq[1] == 8'h00 && seq[2] == 8'h00 && seq[3] == 8'h00
              && seq[4] == 8'h01);
        hdr = r_hp && (r_hcnt == 3'd0);

        n_sync  = r_sync;
        n_drop  = r_drop;
        n_hp    = r_hp;
        n_hcnt  = r_hcnt;
        n_ctype = r_ctype;
        n_hold  = r_hold;
        f_rep   = 1'b0;
        f_end   = 3'd0;
        f_last  = 1'b0;
        f_type  = hdr ? b[4:0] : r_ctype;

        if (acc) begin
            if (r_sync != anbs_pkg::SyncDone) begin
                if (!r_drop) begin
                    if (b == ((r_sync == anbs_pkg::SyncLast) ? 8'h01 : 8'h00)) begin
                        n_sync = r_sync + 3'd1;
                        if (r_sync == anbs_pkg::SyncLast) begin
                            n_hp   = 1'b1;
                            n_hcnt = 3'd0;
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                end
            end else begin
                if (hdr) begin
                    n_ctype = b[4:0];
                    f_rep   = (b[4:0] == anbs_pkg::TypeIdr);
                end
                if (sc) begin
                    f_end  = m5 ? 3'd1 : 3'd0;
                    f_last = 1'b1;
                    n_hcnt = 3'd0;
                    n_hp   = 1'b1;
                end else if (i_in.buffer_last) begin
                    f_end  = r_hcnt + 3'd1;
                    f_last = 1'b1;
                    n_hcnt = 3'd0;
                    n_hp   = 1'b0;
                end else if (m5) begin
                    f_end  = 3'd1;
                    n_hp   = 1'b0;
                    for (int i = 0; i < 4; i++) begin
                        n_hold[i] = seq[i+1];
                    end
                end else begin
                    n_hold[r_hcnt[1:0]] = b;
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
            if (i_in.buffer_last) begin
                n_sync = 3'd0;
                n_drop = 1'b0;
                n_hp   = 1'b0;
                n_hcnt = 3'd0;
            end
        end

        s_rep   = acc ? f_rep : r_p_rep;
        s_bytes = acc ? seq : r_p_byte;
        s_idx   = acc ? 3'd0 : r_p_idx;
        s_end   = acc ? f_end : r_p_end;
        s_hdr   = acc ? r_hp : r_p_hdr;
        s_last  = acc ? f_last : r_p_last;
        s_type  = acc ? f_type : r_p_type;

        push = !i_q_full && (s_rep || (s_idx != s_end));
        o_q_cmd.kind  = s_rep ? anbs_pkg::CmdReplay : anbs_pkg::CmdByte;
        o_q_cmd.data  = s_bytes[s_idx];
        o_q_cmd.utype = s_type;
        o_q_cmd.first = s_hdr && !s_rep;
        o_q_cmd.last  = s_last && !s_rep && ((s_idx + 3'd1) == s_end);

        n_p_rep  = s_rep && !push;
        n_p_idx  = (push && !s_rep) ? s_idx + 3'd1 : s_idx;
        n_p_hdr  = (push && !s_rep) ? 1'b0 : s_hdr;
        n_p_byte = s_bytes;
        n_p_end  = s_end;
        n_p_last = s_last;
        n_p_type = s_type;
    end

    assign o_q_push = push;

    always_ff @(posedge i_clk) begin
        r_hold   <= n_hold;
        r_p_byte <= n_p_byte;
        r_p_last <= n_p_last;
        r_p_type <= n_p_type;
        if (!i_rst_n) begin
            r_sync  <= 3'd0;
            r_drop  <= 1'b0;
            r_hp    <= 1'b0;
            r_hcnt  <= 3'd0;
            r_ctype <= 5'd0;
            r_p_rep <= 1'b0;
            r_p_idx <= 3'd0;
            r_p_end <= 3'd0;
            r_p_hdr <= 1'b0;
        end else begin
            r_sync  <= n_sync;
            r_drop  <= n_drop;
            r_hp    <= n_hp;
            r_hcnt  <= n_hcnt;
            r_ctype <= n_ctype;
            r_p_rep <= n_p_rep;
            r_p_idx <= n_p_idx;
            r_p_end <= n_p_end;
            r_p_hdr <= n_p_hdr;
        end
    end

endmodule

// ----- design/anbs_cmdq.sv -----
// Short command queue between the front and back parts.
// Depends on anbs_pkg for the command type and depth.
module anbs_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  anbs_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output anbs_pkg::t_cmd o_cmd
);

    localparam int unsigned AW = $clog2(anbs_pkg::QueueDepth);
    localparam int unsigned CW = $clog2(anbs_pkg::QueueDepth + 1);

    anbs_pkg::t_cmd r_mem [anbs_pkg::QueueDepth];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(anbs_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(anbs_pkg::QueueDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(anbs_pkg::QueueDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ----- design/anbs_back.sv -----
// Back part: parameter set storage, replay sequencer and output register.
// Depends on anbs_pkg; takes commands from anbs_cmdq.
module anbs_back #(
    parameter int unsigned STORE_BYTES = anbs_pkg::StoreBytesDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_repeat,
    input  logic           i_q_empty,
    input  anbs_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output anbs_pkg::t_out o_out
);

    localparam int unsigned IW = $clog2(STORE_BYTES);
    localparam int unsigned LW = $clog2(STORE_BYTES + 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SPS  = 3'b010,
        S_PPS  = 3'b100
    } t_state;

    t_state         r_state, n_state;
    logic [IW-1:0]  r_idx, n_idx;
    logic           r_ov, n_ov;
    anbs_pkg::t_out r_out, n_out;

    logic [7:0]    r_sps [STORE_BYTES];
    logic [7:0]    r_pps [STORE_BYTES];
    logic [4:0]    r_stype, r_ptype;
    logic [LW-1:0] r_slen, n_slen, r_plen, n_plen;
    logic          r_sv, n_sv, r_pv, n_pv;

    logic          can_out, w_s, w_p;
    logic [LW-1:0] el;
    logic [IW-1:0] w_addr;

    assign o_empty = !r_ov;
    assign o_out   = r_out;
    assign can_out = !r_ov || i_pop;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_ov    = r_ov && !i_pop;
        n_out   = r_out;
        n_slen  = r_slen;
        n_plen  = r_plen;
        n_sv    = r_sv;
        n_pv    = r_pv;
        o_q_pop = 1'b0;
        w_s     = 1'b0;
        w_p     = 1'b0;
        el      = i_q_cmd.first ? '0 : ((i_q_cmd.utype == anbs_pkg::TypeSps) ? r_slen : r_plen);
        w_addr  = el[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && can_out) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.kind == anbs_pkg::CmdByte) begin
                        n_ov  = 1'b1;
                        n_out = '{out_byte: i_q_cmd.data, unit_type: i_q_cmd.utype,
                                  unit_first: i_q_cmd.first, unit_last: i_q_cmd.last,
                                  replayed: 1'b0};
                        if (i_q_cmd.utype == anbs_pkg::TypeSps) begin
                            if (el < LW'(STORE_BYTES)) begin
                                w_s    = 1'b1;
                                n_slen = el + 1'b1;
                            end else begin
                                n_slen = LW'(STORE_BYTES + 1);
                            end
                            if (i_q_cmd.first) begin
                                n_sv = 1'b0;
                            end
                            if (i_q_cmd.last) begin
                                n_sv = (n_slen <= LW'(STORE_BYTES));
                            end
                        end else if (i_q_cmd.utype == anbs_pkg::TypePps) begin
                            if (el < LW'(STORE_BYTES)) begin
                                w_p    = 1'b1;
                                n_plen = el + 1'b1;
                            end else begin
                                n_plen = LW'(STORE_BYTES + 1);
                            end
                            if (i_q_cmd.first) begin
                                n_pv = 1'b0;
                            end
                            if (i_q_cmd.last) begin
                                n_pv = (n_plen <= LW'(STORE_BYTES));
                            end
                        end
                    end else if (i_repeat && r_sv && r_pv) begin
                        n_state = S_SPS;
                        n_idx   = '0;
                    end
                end
            end
            S_SPS: begin
                if (can_out) begin
                    n_ov  = 1'b1;
                    n_out = '{out_byte: r_sps[r_idx], unit_type: r_stype,
                              unit_first: (r_idx == '0),
                              unit_last: ((LW'(r_idx) + 1'b1) == r_slen), replayed: 1'b1};
                    if ((LW'(r_idx) + 1'b1) == r_slen) begin
                        n_state = S_PPS;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_PPS: begin
                if (can_out) begin
                    n_ov  = 1'b1;
                    n_out = '{out_byte: r_pps[r_idx], unit_type: r_ptype,
                              unit_first: (r_idx == '0),
                              unit_last: ((LW'(r_idx) + 1'b1) == r_plen), replayed: 1'b1};
                    if ((LW'(r_idx) + 1'b1) == r_plen) begin
                        n_state = S_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_idx <= n_idx;
        if (w_s) begin
            r_sps[w_addr] <= i_q_cmd.data;
            if (w_addr == '0) begin
                r_stype <= i_q_cmd.data[4:0];
            end
        end
        if (w_p) begin
            r_pps[w_addr] <= i_q_cmd.data;
            if (w_addr == '0) begin
                r_ptype <= i_q_cmd.data[4:0];
            end
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_slen  <= '0;
            r_plen  <= '0;
            r_sv    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_slen  <= n_slen;
            r_plen  <= n_plen;
            r_sv    <= n_sv;
            r_pv    <= n_pv;
        end
    end

endmodule
